### rtl/skt_pkg.sv
// Package for the sorted key table: request and status codes, entry and
// cell command types, default parameter values. No dependencies.
package skt_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_BYTES_DEF = 8;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_LOOKUP = 3'd2,
        REQ_READ   = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] time_val;
        logic [63:0] key;
        logic        del;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic set_del;
        logic clr_del;
    } cell_cmd_t;

endpackage

### rtl/skt_cell.sv
// One table slot: holds an entry, compares it with the current request
// and shifts up from its lower neighbor on insert. Uses skt_pkg.
module skt_cell
    import skt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 11
)
(
    input  logic          clk,
    input  logic [CW-1:0] count,
    input  logic [31:0]   req_time,
    input  logic [63:0]   req_key,
    input  cell_cmd_t     cmd,
    input  entry_t        prev_entry,
    input  logic          prev_lt,
    output entry_t        entry,
    output logic          lt,
    output logic          eq
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid;

    assign valid = 32'(INDEX) < 32'(count);
    assign lt = valid && ((entry_reg.time_val < req_time) ||
                ((entry_reg.time_val == req_time) && (entry_reg.key < req_key)));
    assign eq = valid && (entry_reg.time_val == req_time) && (entry_reg.key == req_key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && !lt)
        begin
            if (prev_lt)
            begin
                entry_next.time_val = req_time;
                entry_next.key      = req_key;
                entry_next.del      = 1'b0;
            end
            else
            begin
                entry_next = prev_entry;
            end
        end
        else if (cmd.set_del && eq)
        begin
            entry_next.del = 1'b1;
        end
        else if (cmd.clr_del && eq)
        begin
            entry_next.del = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/sorted_key_table_with_tombstones.sv
// Top level of the sorted key table: request register, row of skt_cell
// slots, match encoding and the result register. Uses skt_pkg, skt_cell.
//
//  channel | dir | fields
//  s_axis  | in  | tuser: req_type; tdata: time_value, key_bytes, entry_index
//  m_axis  | out | tuser: status; tdata: found .. modified
//
// Each request is first registered from the beat; then every cell
// compares in parallel and the table updates. A new beat is
// taken once the request register is free; a pending result waits in the
// output register and holds execution only while it is not taken.
// Reset clears counts and handshakes; slot contents are not cleared.
module sorted_key_table_with_tombstones
    import skt_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // time_value[31:0], key_bytes[95:32], entry_index[105:96]
    input  logic [2:0]   s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // found, position[11:1], was_deleted, entry_time[44:13],
                                   // entry_key[108:45], entry_count[119:109], modified[120]
    output logic [2:0]   m_tuser   // status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);

    logic          req_valid_reg;
    logic [2:0]    req_type_reg;
    logic [31:0]   req_time_reg;
    logic [63:0]   req_key_reg;
    logic [9:0]    req_idx_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          dirty_reg, dirty_next;
    logic          out_valid_reg;
    logic [127:0]  out_data_reg, out_data_next;
    logic [2:0]    out_user_reg, out_user_next;
    logic          exec;

    cell_cmd_t     cmd;
    entry_t        entries [CAPACITY];
    logic [CAPACITY-1:0] lt_v, eq_v;

    assign s_tready = !req_valid_reg;
    assign exec     = req_valid_reg && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t pe;
            logic   pl;
            if (gi == 0)
            begin : g_first
                assign pe = entries[0];
                assign pl = 1'b1;
            end
            else
            begin : g_rest
                assign pe = entries[gi-1];
                assign pl = lt_v[gi-1];
            end
            skt_cell #(.INDEX(gi), .CW(CW)) u_cell (
                .clk        (clk),
                .count      (count_reg),
                .req_time   (req_time_reg),
                .req_key    (req_key_reg),
                .cmd        (cmd),
                .prev_entry (pe),
                .prev_lt    (pl),
                .entry      (entries[gi]),
                .lt         (lt_v[gi]),
                .eq         (eq_v[gi])
            );
        end
    endgenerate

    logic          hit, hit_del, any_bnd, rd_del;
    logic [CW-1:0] enc, pos;
    logic [31:0]   rd_time;
    logic [63:0]   rd_key;
    logic          full, in_range;
    status_t       status;
    logic [31:0]   o_time;
    logic [63:0]   o_key;
    logic          o_found, o_wdel;
    logic [CW-1:0] o_pos;

    always_comb
    begin
        hit = 1'b0; hit_del = 1'b0; any_bnd = 1'b0; enc = '0;
        rd_del = 1'b0; rd_time = '0; rd_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            // lt flags form a thermometer; the first clear one is the slot
            if (!lt_v[i] && (i == 0 || lt_v[(i == 0) ? 0 : i - 1]))
            begin
                any_bnd = 1'b1;
                enc     = enc | CW'(i);
            end
            if (eq_v[i])
            begin
                hit     = 1'b1;
                hit_del = hit_del | entries[i].del;
            end
            if (32'(i) == 32'(req_idx_reg))
            begin
                rd_del  = rd_del | entries[i].del;
                rd_time = rd_time | entries[i].time_val;
                rd_key  = rd_key | entries[i].key;
            end
        end
        pos      = any_bnd ? enc : CW'(CAPACITY);
        full     = 32'(count_reg) >= 32'(CAPACITY);
        in_range = 32'(req_idx_reg) < 32'(count_reg);

        cmd        = '0;
        count_next = count_reg;
        dirty_next = dirty_reg;
        status     = ST_OK;
        o_found = 1'b0; o_wdel = 1'b0; o_pos = '0; o_time = '0; o_key = '0;
        case (req_type_reg)
            REQ_INSERT, REQ_DELETE, REQ_LOOKUP:
            begin
                o_found = hit;
                o_wdel  = hit_del;
                o_pos   = pos;
                if (req_type_reg == REQ_INSERT)
                begin
                    if (full)
                        status = ST_FULL;
                    else if (hit)
                    begin
                        if (hit_del)
                        begin
                            cmd.clr_del = exec;
                            dirty_next  = 1'b1;
                        end
                        else
                            status = ST_DUP;
                    end
                    else
                    begin
                        cmd.ins    = exec;
                        count_next = count_reg + 1'b1;
                        dirty_next = 1'b1;
                    end
                end
                else if (req_type_reg == REQ_DELETE)
                begin
                    if (hit)
                    begin
                        cmd.set_del = exec;
                        dirty_next  = 1'b1;
                    end
                    else
                        status = ST_NOTFOUND;
                end
                else if (!hit)
                    status = ST_NOTFOUND;
            end
            REQ_READ:
            begin
                if (!in_range)
                    status = ST_RANGE;
                else
                begin
                    o_wdel = rd_del;
                    o_time = rd_time;
                    o_key  = rd_key;
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        out_user_next = status;
        out_data_next = {7'd0, dirty_next, 11'(count_next), o_key, o_time,
                         o_wdel, 11'(o_pos), o_found};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            dirty_reg     <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                req_valid_reg <= 1'b1;
            else if (exec)
                req_valid_reg <= 1'b0;
            if (exec)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                dirty_reg     <= dirty_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_type_reg <= s_tuser;
            req_time_reg <= s_tdata[31:0];
            req_key_reg  <= s_tdata[95:32] & KEY_MASK;
            req_idx_reg  <= s_tdata[105:96];
        end
        if (exec)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule

### sim/skt_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted key table: watches both stream channels, keeps its
// own copy of the table and compares each result beat. Depends on skt_pkg.
module skt_checker
    import skt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [2:0]   m_tuser,
    output int           pending,
    output int           fail_count
);

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [10:0] position;
        logic        was_deleted;
        logic [31:0] entry_time;
        logic [63:0] entry_key;
        logic [10:0] entry_count;
        logic        modified;
    } table_result_t;

    logic [31:0]   tbl_time [1024];
    logic [63:0]   tbl_key  [1024];
    logic          tbl_del  [1024];
    int unsigned   tbl_count;
    logic          tbl_dirty;
    table_result_t results_due[$];

    assign pending = results_due.size();

    // binary search identical in order to the block's definition
    function automatic logic find_slot(input logic [31:0] t, input logic [63:0] k,
                                       output int unsigned pos);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_time[mid] < t || (tbl_time[mid] == t && tbl_key[mid] < k))
                lo = mid + 1;
            else if (tbl_time[mid] == t && tbl_key[mid] == k) begin
                pos = mid;
                return 1'b1;
            end
            else
                hi = mid;
        end
        pos = lo;
        return 1'b0;
    endfunction

    function automatic table_result_t apply_request(input logic [2:0] req,
        input logic [31:0] t, input logic [63:0] k, input logic [9:0] idx);
        table_result_t r;
        int unsigned   pos;
        logic          hit;
        r = '0;
        r.status = ST_OK;
        if (req == REQ_INSERT || req == REQ_DELETE || req == REQ_LOOKUP) begin
            hit = find_slot(t, k, pos);
            r.found = hit;
            r.position = pos[10:0];
            r.was_deleted = hit ? tbl_del[pos] : 1'b0;
            if (req == REQ_INSERT) begin
                if (tbl_count >= 1024)
                    r.status = ST_FULL;
                else if (hit) begin
                    if (tbl_del[pos]) begin
                        tbl_del[pos] = 1'b0;
                        tbl_dirty = 1'b1;
                    end
                    else
                        r.status = ST_DUP;
                end
                else begin
                    for (int unsigned i = tbl_count; i > pos; i--) begin
                        tbl_time[i] = tbl_time[i-1];
                        tbl_key[i]  = tbl_key[i-1];
                        tbl_del[i]  = tbl_del[i-1];
                    end
                    tbl_time[pos] = t;
                    tbl_key[pos]  = k;
                    tbl_del[pos]  = 1'b0;
                    tbl_count++;
                    tbl_dirty = 1'b1;
                end
            end
            else if (req == REQ_DELETE) begin
                if (hit) begin
                    tbl_del[pos] = 1'b1;
                    tbl_dirty = 1'b1;
                end
                else
                    r.status = ST_NOTFOUND;
            end
            else if (!hit)
                r.status = ST_NOTFOUND;
        end
        else if (req == REQ_READ) begin
            if (idx >= tbl_count)
                r.status = ST_RANGE;
            else begin
                r.was_deleted = tbl_del[idx];
                r.entry_time  = tbl_time[idx];
                r.entry_key   = tbl_key[idx];
            end
        end
        else if (req == REQ_CLEAR)
            tbl_count = 0;
        r.entry_count = tbl_count[10:0];
        r.modified = tbl_dirty;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        table_result_t got;
        if (!rst_n) begin
            tbl_count = 0;
            tbl_dirty = 1'b0;
            results_due.delete();
            fail_count = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                results_due.push_back(apply_request(s_tuser, s_tdata[31:0],
                                                    s_tdata[95:32], s_tdata[105:96]));
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[0], m_tdata[11:1], m_tdata[12], m_tdata[44:13],
                       m_tdata[108:45], m_tdata[119:109], m_tdata[120]};
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: %p", got);
                end
                else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

endmodule

### sim/sorted_key_table_with_tombstones_tb.sv
`timescale 1ns / 100ps
// Testbench top for the sorted key table: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on skt_pkg, skt_checker and the table.
module sorted_key_table_with_tombstones_tb;
    import skt_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;
    int           pending;
    int           fail_count;

    logic         quiet;      // no random idling while set
    logic         hold_req;   // ask the receiver for one long hold-off
    int           idle_run;
    logic [31:0]  pool_time [16];
    logic [63:0]  pool_key  [16];

    sorted_key_table_with_tombstones u_dut (.*);

    skt_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send_req(input logic [2:0] req, input logic [31:0] t,
                            input logic [63:0] k, input logic [9:0] idx);
        logic go;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {idx, k, t};
        forever begin
            @(negedge clk);
            go = s_tready;
            @(posedge clk);
            if (go)
                break;
        end
        if (!quiet && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_pool(input logic [2:0] req, input int unsigned n);
        send_req(req, pool_time[n], pool_key[n], 10'($urandom));
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= quiet || $urandom_range(99) >= 6;
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        idle_run = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_run = 0;
            else if (++idle_run >= 5000) begin
                $display("** sorted_key_table_with_tombstones: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned r;
        int unsigned n;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_LOOKUP;
        quiet    = 1'b0;
        hold_req = 1'b0;
        rst_n    = 1'b0;
        for (int i = 0; i < 16; i++) begin
            pool_time[i] = (i < 4) ? 32'($urandom_range(3)) : $urandom;
            pool_key[i]  = {$urandom, $urandom};
        end
        pool_time[0] = '0;
        pool_key[0]  = '0;
        pool_time[1] = '1;
        pool_key[1]  = '1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every request kind, revive, duplicate, misses
        send_req(REQ_READ, 0, 0, 10'd0);
        send_req(REQ_LOOKUP, '0, '0, 10'd0);
        send_req(REQ_DELETE, '1, '1, '1);
        send_req(REQ_INSERT, '1, '1, '1);
        send_req(REQ_INSERT, '0, '0, '0);
        send_req(REQ_INSERT, 32'd5, 64'h8000_0000_0000_0000, 10'd0);
        send_req(REQ_INSERT, 32'd5, 64'h0000_0000_0000_0001, 10'd0);
        send_req(REQ_INSERT, '1, '1, '0);
        send_req(REQ_LOOKUP, 32'd5, 64'h1, 10'd0);
        send_req(REQ_LOOKUP, 32'd5, 64'h2, 10'd0);
        send_req(REQ_DELETE, 32'd5, 64'h1, 10'd0);
        send_req(REQ_DELETE, 32'd5, 64'h1, 10'd0);
        send_req(REQ_READ, 0, 0, 10'd1);
        send_req(REQ_INSERT, 32'd5, 64'h1, 10'd0);
        send_req(REQ_READ, 0, 0, 10'd3);
        send_req(REQ_READ, 0, 0, 10'd4);
        send_req(REQ_READ, 0, 0, '1);
        send_req(3'd5, '1, '1, '1);
        send_req(3'd6, 32'd7, 64'd7, 10'd7);
        send_req(3'd7, 0, 0, 0);
        send_req(REQ_CLEAR, 0, 0, 0);
        send_req(REQ_READ, 0, 0, 10'd0);
        send_req(REQ_LOOKUP, '1, '1, 10'd0);

        // random mix on a small pool of entries so hits are common
        for (int i = 0; i < 400; i++) begin
            quiet = (i >= 60 && i < 140);
            if (i == 200)
                hold_req = 1'b1;
            if (i == 300) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            r = $urandom_range(99);
            n = $urandom_range(15);
            if (r < 35) begin
                if ($urandom_range(3) == 0)
                    send_req(REQ_INSERT, $urandom, {$urandom, $urandom}, 10'($urandom));
                else
                    send_pool(REQ_INSERT, n);
            end
            else if (r < 50)
                send_pool(REQ_DELETE, n);
            else if (r < 68) begin
                if ($urandom_range(3) == 0)
                    send_req(REQ_LOOKUP, $urandom, {$urandom, $urandom}, 10'($urandom));
                else
                    send_pool(REQ_LOOKUP, n);
            end
            else if (r < 94) begin
                if ($urandom_range(4) == 0)
                    send_req(REQ_READ, $urandom, {$urandom, $urandom}, 10'($urandom));
                else
                    send_req(REQ_READ, $urandom, {$urandom, $urandom},
                             10'($urandom_range(15)));
            end
            else if (r < 96)
                send_req(REQ_CLEAR, $urandom, {$urandom, $urandom}, 10'($urandom));
            else
                send_req(3'($urandom_range(5, 7)), $urandom, {$urandom, $urandom},
                         10'($urandom));
        end
        quiet = 1'b0;

        // fill to capacity, then full-table cases
        send_req(REQ_CLEAR, 0, 0, 0);
        for (int i = 0; i < 1024; i++)
            send_req(REQ_INSERT, 32'(i * 3 + 1), {$urandom, $urandom}, 10'($urandom));
        send_req(REQ_INSERT, 32'd4, 64'd0, 10'd0);
        send_req(REQ_INSERT, '1, '1, 10'd0);
        send_req(REQ_READ, 0, 0, 10'd1023);
        send_req(REQ_LOOKUP, 32'd4, 64'd0, 10'd0);
        send_req(REQ_READ, 0, 0, 10'd0);
        send_req(REQ_CLEAR, 0, 0, 0);
        send_req(REQ_READ, 0, 0, 10'd0);
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** sorted_key_table_with_tombstones: PASSED **");
        else
            $display("** sorted_key_table_with_tombstones: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table_with_tombstones.sv
sim/skt_checker.sv
sim/sorted_key_table_with_tombstones_tb.sv
